@@ rtl/timed_counting_semaphore_assert.svh @@
// Assertion macros for the timed counting semaphore
`ifndef TIMED_COUNTING_SEMAPHORE_ASSERT_SVH
`define TIMED_COUNTING_SEMAPHORE_ASSERT_SVH
// implication checked every clock outside reset
`define TCS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define TCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/tcs_pkg.sv @@
// ----------------------------------------------------------------------------
// tcs_pkg
// Types and constants shared by the timed counting semaphore.
// ----------------------------------------------------------------------------
`default_nettype none
package tcs_pkg;
    localparam int MAX_WAITERS_DEF = 16;
    localparam int CNT_W = 17;
    localparam logic signed [CNT_W-1:0] COUNT_MIN = -17'sd65536;
    localparam logic signed [CNT_W-1:0] COUNT_MAX = 17'sd65535;

    localparam logic [1:0] CMD_WAIT   = 2'd0;
    localparam logic [1:0] CMD_SIGNAL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_FLUSH  = 2'd3;

    localparam logic [2:0] ST_PASSED   = 3'd0;
    localparam logic [2:0] ST_BLOCKED  = 3'd1;
    localparam logic [2:0] ST_SIGNAL   = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_DELETE   = 3'd4;
    localparam logic [2:0] ST_NOTHING  = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;

    localparam logic [1:0] REG_INITIAL_COUNT = 2'd0;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  thread_id;
        logic [15:0] timeout;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] released_thread;
        logic       last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load_cfg;
        logic do_wait;
        logic do_signal;
        logic scan_start;
        logic scan_step;
        logic flush_pop;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       full;
        logic       empty;
        logic       wait_blocks;
        logic       signal_rel;
        logic       scan_done;
        logic       scan_fire;
        logic       flush_last;
        logic [7:0] head_thread;
        logic [7:0] scan_thread;
    } dp_status_t;
endpackage
`default_nettype wire

@@ rtl/timed_counting_semaphore.sv @@
// ----------------------------------------------------------------------------
// timed_counting_semaphore
// Counting semaphore with a FIFO of waiting threads and per-waiter timeouts.
// ----------------------------------------------------------------------------
// Wait and signal each yield one result. A tick walks the waiter slots in
// order and emits one result per timed-out waiter, or a single nothing result
// when none times out; release-all pops one waiter per cycle while the output
// register has room, or emits a single nothing result when the queue is empty.
// The sequencer handles one transaction at a time; results stall the walk
// while the output register is full. Writing initial_count also loads the
// count.
`default_nettype none
module timed_counting_semaphore #(
    parameter int MAX_WAITERS = tcs_pkg::MAX_WAITERS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tcs_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tcs_pkg::out_item_t      m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    `include "timed_counting_semaphore_assert.svh"

    logic [14:0] init_reg;
    logic cfg_write, reg_hit;
    tcs_pkg::dp_cmd_t    cmd;
    tcs_pkg::dp_status_t status;

    assign pready    = 1'b1;
    assign reg_hit   = (paddr == {tcs_pkg::REG_INITIAL_COUNT});
    assign cfg_write = psel && penable && pwrite && reg_hit;
    assign prdata    = reg_hit ? {17'd0, init_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= '0;
        end else if (cfg_write) begin
            init_reg <= pwdata[14:0];
        end
    end

    tcs_controller u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data, .cfg_write, .status, .cmd
    );

    tcs_datapath #(.MAX_WAITERS(MAX_WAITERS)) u_dp (
        .aclk, .aresetn, .cmd, .item(s_data), .cfg_count(pwdata[14:0]), .status
    );

    `TCS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `TCS_ASSERT_IMP(a_one_op, aclk, aresetn, 1'b1,
        $onehot0({cmd.do_wait, cmd.do_signal, cmd.scan_step, cmd.flush_pop}))
    `TCS_ASSERT_IMP(a_no_wait_full, aclk, aresetn, cmd.do_wait, !status.full)
endmodule
`default_nettype wire

@@ rtl/tcs_datapath.sv @@
// ----------------------------------------------------------------------------
// tcs_datapath
// Semaphore count and waiter queue held as shifting register slots.
// ----------------------------------------------------------------------------
`default_nettype none
module tcs_datapath #(
    parameter int MAX_WAITERS = tcs_pkg::MAX_WAITERS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tcs_pkg::dp_cmd_t     cmd,
    input  wire tcs_pkg::in_item_t    item,
    input  wire logic [14:0]          cfg_count,
    output tcs_pkg::dp_status_t       status
);
    localparam int IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int TW = $clog2(MAX_WAITERS + 1);

    logic signed [tcs_pkg::CNT_W-1:0] count_reg, count_next, cnt_dec, cnt_inc;
    logic [TW-1:0] total_reg, total_next;
    logic [TW-1:0] scan_reg, scan_next;
    logic [7:0]  thr_reg [MAX_WAITERS];
    logic [15:0] lim_reg [MAX_WAITERS];
    logic [15:0] ela_reg [MAX_WAITERS];
    logic [IW-1:0] sidx;
    logic [15:0] ela_inc;
    logic remove;
    logic [IW-1:0] ridx;

    assign sidx = scan_reg[IW-1:0];
    assign cnt_dec = (count_reg > tcs_pkg::COUNT_MIN) ? count_reg - 17'sd1 : count_reg;
    assign cnt_inc = (count_reg < tcs_pkg::COUNT_MAX) ? count_reg + 17'sd1 : count_reg;
    assign ela_inc = ela_reg[sidx] + 16'd1;

    always_comb begin
        status.full        = (total_reg == TW'(MAX_WAITERS));
        status.empty       = (total_reg == '0);
        status.wait_blocks = cnt_dec < 0;
        status.signal_rel  = (cnt_inc <= 0) && (total_reg != '0);
        status.scan_done   = (scan_reg >= total_reg);
        status.scan_fire   = (lim_reg[sidx] != '0) && (ela_inc == lim_reg[sidx]);
        status.flush_last  = (total_reg == TW'(1));
        status.head_thread = thr_reg[0];
        status.scan_thread = thr_reg[sidx];
    end

    always_comb begin
        count_next = count_reg;
        total_next = total_reg;
        scan_next  = scan_reg;
        remove     = 1'b0;
        ridx       = '0;
        if (cmd.load_cfg) begin
            count_next = tcs_pkg::CNT_W'(cfg_count);
        end
        if (cmd.do_wait) begin
            count_next = cnt_dec;
            if (status.wait_blocks) begin
                total_next = total_reg + TW'(1);
            end
        end
        if (cmd.do_signal) begin
            count_next = cnt_inc;
            if (status.signal_rel) begin
                remove = 1'b1;
            end
        end
        if (cmd.flush_pop) begin
            remove = 1'b1;
        end
        if (cmd.scan_start) begin
            scan_next = '0;
        end
        if (cmd.scan_step) begin
            if (status.scan_fire) begin
                remove = 1'b1;
                ridx   = sidx;
            end else begin
                scan_next = scan_reg + TW'(1);
            end
        end
        if (remove) begin
            total_next = total_reg - TW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            total_reg <= '0;
            scan_reg  <= '0;
        end else begin
            count_reg <= count_next;
            total_reg <= total_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_WAITERS; i++) begin
            if (cmd.do_wait && status.wait_blocks && (total_reg == TW'(i))) begin
                thr_reg[i] <= item.thread_id;
                lim_reg[i] <= item.timeout;
                ela_reg[i] <= '0;
            end else if (remove && (TW'(i) >= TW'(ridx))) begin
                if (i + 1 < MAX_WAITERS) begin
                    thr_reg[i] <= thr_reg[(i + 1) % MAX_WAITERS];
                    lim_reg[i] <= lim_reg[(i + 1) % MAX_WAITERS];
                    ela_reg[i] <= ela_reg[(i + 1) % MAX_WAITERS];
                end
            end else if (cmd.scan_step && (TW'(i) == scan_reg) && lim_reg[i] != '0) begin
                ela_reg[i] <= ela_inc;
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/tcs_controller.sv @@
// ----------------------------------------------------------------------------
// tcs_controller
// Sequencer: accepts a transaction, drives the datapath, produces results.
// ----------------------------------------------------------------------------
`default_nettype none
module tcs_controller (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tcs_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tcs_pkg::out_item_t       m_data,
    input  wire logic                cfg_write,
    input  wire tcs_pkg::dp_status_t status,
    output tcs_pkg::dp_cmd_t         cmd
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   fired_reg, fired_next;
    logic   mv_reg, mv_next;
    tcs_pkg::out_item_t md_reg, md_next;
    logic   accept, slot_free;

    assign slot_free = !mv_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;
    assign m_valid   = mv_reg;
    assign m_data    = md_reg;

    always_comb begin
        state_next = state_reg;
        fired_next = fired_reg;
        mv_next    = mv_reg && !m_ready;
        md_next    = md_reg;
        cmd        = '0;
        cmd.load_cfg = cfg_write;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mv_next = 1'b1;
                    md_next.last = 1'b1;
                    md_next.released_thread = s_data.thread_id;
                    case (s_data.command)
                        tcs_pkg::CMD_WAIT: begin
                            if (status.full) begin
                                md_next.status = tcs_pkg::ST_FULL;
                            end else begin
                                cmd.do_wait = 1'b1;
                                md_next.status = status.wait_blocks ?
                                    tcs_pkg::ST_BLOCKED : tcs_pkg::ST_PASSED;
                            end
                        end
                        tcs_pkg::CMD_SIGNAL: begin
                            cmd.do_signal = 1'b1;
                            if (status.signal_rel) begin
                                md_next.status = tcs_pkg::ST_SIGNAL;
                                md_next.released_thread = status.head_thread;
                            end else begin
                                md_next.status = tcs_pkg::ST_NOTHING;
                                md_next.released_thread = '0;
                            end
                        end
                        tcs_pkg::CMD_TICK: begin
                            mv_next = 1'b0;
                            cmd.scan_start = 1'b1;
                            fired_next = 1'b0;
                            state_next = S_SCAN;
                        end
                        default: begin
                            mv_next = 1'b0;
                            state_next = S_FLUSH;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (status.scan_done) begin
                    if (!fired_reg) begin
                        state_next = S_OUT;
                    end else if (slot_free) begin
                        state_next = S_IDLE;
                    end
                end else if (slot_free) begin
                    if (status.scan_fire && fired_reg) begin
                        mv_next = 1'b1;
                        fired_next = 1'b0;
                    end else begin
                        cmd.scan_step = 1'b1;
                        if (status.scan_fire) begin
                            fired_next = 1'b1;
                            md_next.status = tcs_pkg::ST_TIMEOUT;
                            md_next.released_thread = status.scan_thread;
                            md_next.last = 1'b0;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (status.empty) begin
                    state_next = S_OUT;
                end else if (slot_free) begin
                    cmd.flush_pop = 1'b1;
                    mv_next = 1'b1;
                    md_next.status = tcs_pkg::ST_DELETE;
                    md_next.released_thread = status.head_thread;
                    md_next.last = status.flush_last;
                    if (status.flush_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    mv_next = 1'b1;
                    md_next.status = tcs_pkg::ST_NOTHING;
                    md_next.released_thread = '0;
                    md_next.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // on a tick, hold the last found timeout until the walk ends, then release it as last
        if (state_reg == S_SCAN && status.scan_done && fired_reg && slot_free) begin
            mv_next = 1'b1;
            fired_next = 1'b0;
            md_next.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
            fired_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            fired_reg <= fired_next;
        end
    end

    always_ff @(posedge aclk) begin
        md_reg <= md_next;
    end
endmodule
`default_nettype wire
